// ----- hw/rtl/pilp_pkg.sv -----
// Shared types, character codes and digit helpers for the integer literal parser.
// No dependencies.
package pilp_pkg;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_AFTER_SIGN,
    PH_AFTER_ZERO,
    PH_DIGITS,
    PH_ENDED
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_OCT,
    BASE_HEX,
    BASE_BIN
  } base_t;

  // Parser control state, passed between the top level and the step logic
  typedef struct packed {
    phase_t phase;
    logic   negative;
    base_t  base;
  } ctrl_t;

  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_UPPER_B = 8'h42;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CASE_GAP   = 8'h20;
  localparam logic [7:0] NOT_DIGIT  = 8'hff;
  localparam logic [7:0] LETTER_OFS = 8'd10;

  localparam ctrl_t CTRL_RESET = '{phase: PH_FIRST, negative: 1'b0, base: BASE_DEC};

  function automatic logic [7:0] upper_of(input logic [7:0] c);
    upper_of = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_GAP : c;
  endfunction

  // Digit value for bases up to 36, NOT_DIGIT otherwise
  function automatic logic [7:0] digit_of(input logic [7:0] c);
    logic [7:0] u;
    u = upper_of(c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      digit_of = c - CH_ZERO;
    end else if (u >= CH_UPPER_A && u <= CH_UPPER_Z) begin
      digit_of = u - CH_UPPER_A + LETTER_OFS;
    end else begin
      digit_of = NOT_DIGIT;
    end
  endfunction

  function automatic logic [4:0] radix_of(input base_t b);
    case (b)
      BASE_DEC: radix_of = 5'd10;
      BASE_OCT: radix_of = 5'd8;
      BASE_HEX: radix_of = 5'd16;
      default:  radix_of = 5'd2;
    endcase
  endfunction

endpackage

// ----- hw/rtl/pilp_step.sv -----
// Next-state logic of the literal parser for one character.
// Depends on pilp_pkg.
module pilp_step #(
  parameter int VALUE_WIDTH = 32
) (
  input  pilp_pkg::ctrl_t         st,
  input  logic [VALUE_WIDTH-1:0]  acc,
  input  logic [7:0]              ch,
  input  logic                    start_req,
  output pilp_pkg::ctrl_t         st_next,
  output logic [VALUE_WIDTH-1:0]  acc_next
);
  import pilp_pkg::*;

  ctrl_t                  cur;
  logic [VALUE_WIDTH-1:0] cur_acc;
  logic [VALUE_WIDTH-1:0] scaled;
  logic [7:0]             dig;
  logic [7:0]             up;
  logic                   do_take;
  logic                   first_char;

  assign cur     = start_req ? CTRL_RESET : st;
  assign cur_acc = start_req ? '0 : acc;
  assign dig     = digit_of(ch);
  assign up      = upper_of(ch);

  always_comb begin
    st_next    = cur;
    acc_next   = cur_acc;
    do_take    = 1'b0;
    first_char = 1'b0;
    scaled     = '0;

    unique case (cur.phase)
      PH_FIRST: begin
        if (ch == CH_MINUS) begin
          st_next.negative = 1'b1;
          st_next.phase    = PH_AFTER_SIGN;
        end else begin
          first_char = 1'b1;
        end
      end
      PH_AFTER_SIGN: first_char = 1'b1;
      PH_AFTER_ZERO: begin
        st_next.phase = PH_DIGITS;
        if (up == CH_UPPER_X) begin
          st_next.base = BASE_HEX;
        end else if (up == CH_UPPER_B) begin
          st_next.base = BASE_BIN;
        end else begin
          do_take = 1'b1;
        end
      end
      PH_DIGITS: do_take = 1'b1;
      default:   st_next.phase = PH_ENDED;
    endcase

    if (first_char) begin
      if (ch == CH_ZERO) begin
        st_next.base  = BASE_OCT;
        st_next.phase = PH_AFTER_ZERO;
      end else begin
        st_next.base  = BASE_DEC;
        st_next.phase = PH_DIGITS;
        do_take       = 1'b1;
      end
    end

    // acc * radix as shifts; the radix is always a small constant
    case (st_next.base)
      BASE_DEC: scaled = (cur_acc << 3) + (cur_acc << 1);
      BASE_OCT: scaled = cur_acc << 3;
      BASE_HEX: scaled = cur_acc << 4;
      default:  scaled = cur_acc << 1;
    endcase

    if (do_take) begin
      if (dig < {3'b000, radix_of(st_next.base)}) begin
        acc_next = scaled + VALUE_WIDTH'(dig);
      end else begin
        st_next.phase = PH_ENDED;
      end
    end
  end

endmodule

// ----- hw/rtl/prefixed_integer_literal_parser.sv -----
// Top level of the prefixed integer literal parser: state and result registers.
// Depends on pilp_pkg and pilp_step.
//
// Usage:
//   One character byte enters per item on the input channel (ch, start_req
//   with in_valid/in_ready); start_req high makes that character begin a new
//   literal. Each item gives exactly one result item on the output channel
//   (value, ended, base_code with out_valid/out_ready).
//   Latency: the result is presented the cycle after the item is accepted.
//   Throughput: one item per cycle unless the output stalls. The parser
//   state update is a shift-and-add of the accumulator by the base, done in
//   the accepting cycle, so successive characters never wait on each other.
//   The output register holds a result until taken; in_ready stays high
//   while it is empty or being taken in the same cycle, so a stalled receiver
//   stops input only once the register is full.
//   Reset clears the parser to expect a sign or first character, decimal
//   base, zero accumulator, and empties the output register.
//   VALUE_WIDTH sets the accumulator width; value is the signed result
//   sign-extended or truncated to 32 bits.
module prefixed_integer_literal_parser #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         ch,
  input  logic               start_req,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] value,
  output logic               ended,
  output logic [1:0]         base_code
);
  import pilp_pkg::*;

  ctrl_t                         st;
  ctrl_t                         st_next;
  logic [VALUE_WIDTH-1:0]        acc;
  logic [VALUE_WIDTH-1:0]        acc_next;
  logic signed [VALUE_WIDTH-1:0] signed_next;
  logic                          accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  pilp_step #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_step (
    .st       (st),
    .acc      (acc),
    .ch       (ch),
    .start_req(start_req),
    .st_next  (st_next),
    .acc_next (acc_next)
  );

  assign signed_next = st_next.negative ? $signed(-acc_next) : $signed(acc_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= CTRL_RESET;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        st  <= st_next;
        acc <= acc_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value     <= 32'(signed_next);
      ended     <= (st_next.phase == PH_ENDED);
      base_code <= st_next.base;
    end
  end

endmodule

// ----- hw/rtl/pilp_checker.sv -----
// Port-level checks for the integer literal parser, bound to the top level.
// Depends on pilp_pkg and prefixed_integer_literal_parser.
module pilp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [7:0]         ch,
  input logic               start_req,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] value,
  input logic               ended,
  input logic [1:0]         base_code
);
  import pilp_pkg::*;

  // held result must not change while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(ended)
      && $stable(base_code))
    else $error("result changed while stalled");

  // every accepted item shows its result on the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("missing result after accepted item");

  // input back-pressure only comes from a full, stalled output register
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  // a fresh literal starting with a minus: zero, not ended, decimal
  a_minus: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && start_req && ch == CH_MINUS
      |=> value == 32'sd0 && !ended && base_code == BASE_DEC)
    else $error("lone minus result wrong");

  // a fresh literal starting with zero selects octal
  a_zero: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && start_req && ch == CH_ZERO
      |=> value == 32'sd0 && !ended && base_code == BASE_OCT)
    else $error("leading zero result wrong");

endmodule

bind prefixed_integer_literal_parser pilp_checker u_pilp_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for prefixed_integer_literal_parser: a directed character table, then random
// literals under several idling phases, each result checked against a behavioural parser
// or, for typed rows, the table. Depends on pilp_pkg and the parser RTL.
module tb_top;
  import pilp_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 460;
  localparam int MAX_PRINTED     = 30;
  localparam logic [4:0] RADIX_TAB [4] = '{5'd10, 5'd8, 5'd16, 5'd2};

  typedef struct packed {
    logic [31:0] value;
    logic        ended;
    base_t       base;
  } lit_res_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       start;
    logic       typed;
    lit_res_t   res;
  } char_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         ch = 8'h00;
  logic               start_req = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] value;
  logic               ended;
  logic [1:0]         base_code;

  // behavioural parser state
  phase_t      lit_phase;
  logic        lit_neg;
  base_t       lit_base;
  logic [31:0] lit_acc;

  lit_res_t  lit_q [$];
  char_row_t directed_q [$];
  int        errors = 0;
  int        stuck_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_left = 0;
  bit        hold_req = 1'b0;

  prefixed_integer_literal_parser uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .ch(ch), .start_req(start_req),
    .out_valid(out_valid), .out_ready(out_ready),
    .value(value), .ended(ended), .base_code(base_code)
  );

  always #5 clk = ~clk;

  function automatic void clear_literal();
    lit_phase = PH_FIRST;
    lit_neg   = 1'b0;
    lit_base  = BASE_DEC;
    lit_acc   = '0;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      return c - CASE_GAP;
    end
    return c;
  endfunction

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] u;
    u = fold_case(c);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return c - CH_ZERO;
    end else if (u >= CH_UPPER_A && u <= CH_UPPER_Z) begin
      return u - CH_UPPER_A + LETTER_OFS;
    end
    return NOT_DIGIT;
  endfunction

  // digit in the current base is folded in; anything else ends the literal
  function automatic void accumulate(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] r;
    d = digit_value(c);
    r = RADIX_TAB[lit_base];
    if (d < {3'b000, r}) begin
      lit_acc = lit_acc * {27'd0, r} + {24'd0, d};
    end else begin
      lit_phase = PH_ENDED;
    end
  endfunction

  function automatic lit_res_t parse_char(input logic [7:0] c, input logic s);
    lit_res_t r;
    if (s) begin
      clear_literal();
    end
    case (lit_phase)
      PH_FIRST, PH_AFTER_SIGN: begin
        if (lit_phase == PH_FIRST && c == CH_MINUS) begin
          lit_neg   = 1'b1;
          lit_phase = PH_AFTER_SIGN;
        end else if (c == CH_ZERO) begin
          lit_base  = BASE_OCT;
          lit_phase = PH_AFTER_ZERO;
        end else begin
          lit_base  = BASE_DEC;
          lit_phase = PH_DIGITS;
          accumulate(c);
        end
      end
      PH_AFTER_ZERO: begin
        lit_phase = PH_DIGITS;
        if (fold_case(c) == CH_UPPER_X) begin
          lit_base = BASE_HEX;
        end else if (fold_case(c) == CH_UPPER_B) begin
          lit_base = BASE_BIN;
        end else begin
          accumulate(c);
        end
      end
      PH_DIGITS: begin
        accumulate(c);
      end
      default: begin
        lit_phase = PH_ENDED;
      end
    endcase
    r.value = lit_neg ? -lit_acc : lit_acc;
    r.ended = (lit_phase == PH_ENDED);
    r.base  = lit_base;
    return r;
  endfunction

  task automatic report_err(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("mismatch: %s", msg);
    end
  endtask

  // offer one character; valid is only lowered on a negedge where nothing new goes out
  task automatic offer(input logic [7:0] c, input logic s, input logic typed,
                       input lit_res_t typed_res);
    lit_res_t pred;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    ch        <= c;
    start_req <= s;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    pred = parse_char(c, s);
    lit_q.push_back(typed ? typed_res : pred);
  endtask

  function automatic void add_row(input logic [7:0] c, input logic s, input logic typed,
                                  input logic [31:0] v, input logic e, input base_t b);
    char_row_t r;
    r.ch    = c;
    r.start = s;
    r.typed = typed;
    r.res   = '{value: v, ended: e, base: b};
    directed_q.push_back(r);
  endfunction

  // one well-formed literal with random content, or a burst of noise
  task automatic send_literal(inout int sent);
    logic [7:0] q [$];
    base_t      b;
    int         n;
    int         d;
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(6, 1);
      repeat (n) offer(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
      sent += n;
      return;
    end
    if ($urandom_range(3) == 0) begin
      q.push_back(CH_MINUS);
    end
    case ($urandom_range(3))
      0: b = BASE_DEC;
      1: b = BASE_OCT;
      2: b = BASE_HEX;
      default: b = BASE_BIN;
    endcase
    if (b != BASE_DEC) begin
      q.push_back(CH_ZERO);
    end
    if (b == BASE_HEX) begin
      q.push_back($urandom_range(1) ? 8'("x") : CH_UPPER_X);
    end else if (b == BASE_BIN) begin
      q.push_back($urandom_range(1) ? 8'("b") : CH_UPPER_B);
    end
    // an occasional long run drives the accumulator round its wrap
    n = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(10, 0);
    for (int i = 0; i < n; i++) begin
      d = $urandom_range(int'(RADIX_TAB[b]) - 1);
      if (b == BASE_DEC && i == 0 && d == 0) begin
        d = 1;  // leading zero would switch to octal
      end
      if (d < 10) begin
        q.push_back(CH_ZERO + 8'(d));
      end else begin
        q.push_back(($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + 8'(d - 10));
      end
    end
    if ($urandom_range(4) != 0) begin
      q.push_back(8'($urandom_range(255)));
    end
    foreach (q[i]) begin
      offer(q[i], i == 0, 1'b0, '0);
    end
    sent += q.size();
    // trailing characters without a start; the parser ignores them once the literal has ended
    n = $urandom_range(2);
    repeat (n) offer(8'($urandom_range(255)), 1'b0, 1'b0, '0);
    sent += n;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    lit_res_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (lit_q.size() == 0) begin
          report_err($sformatf("unexpected result value %0d", value));
        end else begin
          want = lit_q.pop_front();
          if (value !== want.value) begin
            report_err($sformatf("value %0d, want %0d", value, $signed(want.value)));
          end
          if (ended !== want.ended) begin
            report_err($sformatf("ended %b, want %b (value %0d)", ended, want.ended, value));
          end
          if (base_code !== want.base) begin
            report_err($sformatf("base_code %0d, want %0d (value %0d)", base_code,
                                 want.base, value));
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
          $display("tb_top: errors");
          $finish;
        end
      end
    end
  end

  initial begin
    int sent;
    bit hold_done;
    clear_literal();
    // lone minus, then minus followed by a non-digit
    add_row(CH_MINUS, 1'b1, 1'b1, 32'd0, 1'b0, BASE_DEC);
    add_row(CH_MINUS, 1'b0, 1'b1, 32'd0, 1'b1, BASE_DEC);
    // zero then a non-octal digit
    add_row(CH_ZERO,  1'b1, 1'b1, 32'd0, 1'b0, BASE_OCT);
    add_row("8",      1'b0, 1'b1, 32'd0, 1'b1, BASE_OCT);
    // hex prefix ended by a non-digit; binary prefix, a digit, then a non-binary digit
    add_row(CH_ZERO,  1'b1, 1'b1, 32'd0, 1'b0, BASE_OCT);
    add_row("x",      1'b0, 1'b1, 32'd0, 1'b0, BASE_HEX);
    add_row("g",      1'b0, 1'b1, 32'd0, 1'b1, BASE_HEX);
    add_row(CH_ZERO,  1'b1, 1'b1, 32'd0, 1'b0, BASE_OCT);
    add_row("B",      1'b0, 1'b1, 32'd0, 1'b0, BASE_BIN);
    add_row("1",      1'b0, 1'b0, 32'd0, 1'b0, BASE_DEC);
    add_row("2",      1'b0, 1'b0, 32'd0, 1'b0, BASE_DEC);
    // negative hex, mixed-case digits, ended by a letter beyond f
    add_row(CH_MINUS, 1'b1, 1'b1, 32'd0, 1'b0, BASE_DEC);
    add_row(CH_ZERO,  1'b0, 1'b1, 32'd0, 1'b0, BASE_OCT);
    add_row("X",      1'b0, 1'b1, 32'd0, 1'b0, BASE_HEX);
    add_row("f",      1'b0, 1'b0, 32'd0, 1'b0, BASE_DEC);
    add_row("F",      1'b0, 1'b0, 32'd0, 1'b0, BASE_DEC);
    add_row("A",      1'b0, 1'b0, 32'd0, 1'b0, BASE_DEC);
    add_row("9",      1'b0, 1'b0, 32'd0, 1'b0, BASE_DEC);
    add_row("z",      1'b0, 1'b0, 32'd0, 1'b0, BASE_DEC);
    // high byte never a digit; characters after the end are ignored
    add_row(8'hff,    1'b1, 1'b1, 32'd0, 1'b1, BASE_DEC);
    add_row(8'h00,    1'b0, 1'b1, 32'd0, 1'b1, BASE_DEC);
    add_row("9",      1'b1, 1'b0, 32'd0, 1'b0, BASE_DEC);
    add_row("9",      1'b0, 1'b0, 32'd0, 1'b0, BASE_DEC);
    add_row(8'h80,    1'b0, 1'b0, 32'd0, 1'b0, BASE_DEC);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_q[i]) begin
      offer(directed_q[i].ch, directed_q[i].start, directed_q[i].typed, directed_q[i].res);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      sent = 0;
      hold_done = 1'b0;
      while (sent < ITEMS_PER_PHASE) begin
        send_literal(sent);
        // mid-way through the unthrottled phase the receiver holds off so the block backs up
        if (ph == 0 && !hold_done && sent >= ITEMS_PER_PHASE / 2) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (lit_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
